// ===== rtl/pwa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwa_pkg
// Shared types and constants of the periodic window averager.
// ----------------------------------------------------------------------------
package pwa_pkg;

  localparam int unsigned TS_W    = 31;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned DIST_W  = 20;
  localparam int unsigned EVERY_W = 16;
  localparam int unsigned REP_W   = 11;
  localparam int unsigned START_W = 31;
  localparam int unsigned SPAN_W  = REP_W + EVERY_W;
  localparam int unsigned STEP_W  = $clog2(SUM_W + 1);

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_EVERY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STEP    = 2'd3;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] AVG_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] AVG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [DIST_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SUM_W-1:0]  quot;
    logic [DIST_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/periodic_window_averager.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_window_averager
// Per-slot windowed average of Q16.16 samples over periodic timestep windows.
// ----------------------------------------------------------------------------
// One item at a time: the block accepts no new item until the result of the last
// one is loaded into the output register, which may wait on m_axis_tready_i. Each
// item runs through the single bit-serial divider: timestep mod period (31 steps),
// distance mod sample_every (20 steps) and, for a sampled item at a window end,
// the 48 bit sum divided by repeat_count (48 steps). After reset the block clears
// its sum memory and accepts no item meanwhile; configuration writes are taken at
// any time.
module periodic_window_averager #(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // cfg_index_i selects: 0 sample_every, 1 repeat_count, 2 window_period,
  // 3 start_step
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pwa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pwa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [30:0] timestep, [36:31] slot, [68:37] sample_value, [71:69] zero
  input  wire logic [pwa_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // last_slot
  input  wire logic                              s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [5:0] slot_out, [37:6] average, [39:38] zero
  output logic      [pwa_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // [0] sampled, [1] window_done
  output logic      [pwa_pkg::OUT_USER_W-1:0]    m_axis_tuser_o,
  // last_out
  output logic                                   m_axis_tlast_o
);

  localparam int unsigned AddrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [3:0] S_CLEAR       = 4'd0;
  localparam logic [3:0] S_IDLE        = 4'd1;
  localparam logic [3:0] S_WAIT_PER    = 4'd2;
  localparam logic [3:0] S_START_EVERY = 4'd3;
  localparam logic [3:0] S_WAIT_EVERY  = 4'd4;
  localparam logic [3:0] S_ACC         = 4'd5;
  localparam logic [3:0] S_START_AVG   = 4'd6;
  localparam logic [3:0] S_WAIT_AVG    = 4'd7;
  localparam logic [3:0] S_OUT         = 4'd8;

  logic [3:0]                      state_q, state_d;
  logic [AddrW-1:0]                clr_q, clr_d;

  logic [pwa_pkg::EVERY_W-1:0]     every_q;
  logic [pwa_pkg::REP_W-1:0]       rep_q;
  logic [pwa_pkg::DIST_W-1:0]      per_q;
  logic [pwa_pkg::START_W-1:0]     start_q;
  logic [pwa_pkg::EVERY_W-1:0]     every_eff;
  logic [pwa_pkg::REP_W-1:0]       rep_eff;
  logic [pwa_pkg::DIST_W-1:0]      per_eff;

  logic [pwa_pkg::TS_W-1:0]        ts_q;
  logic [pwa_pkg::SLOT_W-1:0]      slot_q;
  logic signed [pwa_pkg::VAL_W-1:0] sample_q;
  logic                            last_q;
  logic [pwa_pkg::SPAN_W-1:0]      span_q;
  logic [pwa_pkg::DIST_W-1:0]      dist_q, dist_d;
  logic                            take_q, take_d;
  logic                            first_q, first_d;
  logic                            end_q, end_d;
  logic [pwa_pkg::SUM_W-1:0]       sum_q, sum_d;

  logic                            out_valid_q;
  logic [pwa_pkg::SLOT_W-1:0]      out_slot_q;
  logic [pwa_pkg::VAL_W-1:0]       out_avg_q;
  logic                            out_sampled_q;
  logic                            out_done_q;
  logic                            out_last_q;

  logic                            accept;
  logic                            out_free;
  logic                            out_load;
  logic                            slot_ok;
  logic [pwa_pkg::SUM_W-1:0]       base;
  logic [pwa_pkg::SUM_W:0]         acc_sum;
  logic [pwa_pkg::SUM_W-1:0]       acc_sat;
  logic [pwa_pkg::SUM_W-1:0]       sum_abs;
  logic [pwa_pkg::VAL_W-1:0]       avg_sat;

  logic                            ram_we;
  logic [AddrW-1:0]                ram_waddr;
  logic [pwa_pkg::SUM_W-1:0]       ram_wdata;
  logic [AddrW-1:0]                slot_addr;
  logic [pwa_pkg::SUM_W-1:0]       ram_rdata;

  pwa_pkg::div_req_t               div_req;
  pwa_pkg::div_rsp_t               div_rsp;

  assign every_eff = (every_q == '0) ? pwa_pkg::EVERY_W'(1) : every_q;
  assign rep_eff   = (rep_q == '0) ? pwa_pkg::REP_W'(1) : rep_q;
  assign per_eff   = (per_q == '0) ? pwa_pkg::DIST_W'(1) : per_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = (state_q == S_OUT) && out_free;
  assign slot_ok         = 32'(slot_q) < 32'(SLOTS);
  assign slot_addr       = AddrW'(slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      every_q <= pwa_pkg::EVERY_W'(1);
      rep_q   <= pwa_pkg::REP_W'(1);
      per_q   <= pwa_pkg::DIST_W'(1);
      start_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pwa_pkg::CFG_SAMPLE_EVERY:  every_q <= cfg_data_i[pwa_pkg::EVERY_W-1:0];
        pwa_pkg::CFG_REPEAT_COUNT:  rep_q   <= cfg_data_i[pwa_pkg::REP_W-1:0];
        pwa_pkg::CFG_WINDOW_PERIOD: per_q   <= cfg_data_i[pwa_pkg::DIST_W-1:0];
        pwa_pkg::CFG_START_STEP:    start_q <= cfg_data_i[pwa_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_req       = '0;
    div_req.steps = pwa_pkg::STEP_W'(pwa_pkg::TS_W);
    case (state_q)
      S_IDLE: begin
        div_req.start    = accept;
        div_req.dividend = {s_axis_tdata_i[pwa_pkg::TS_W-1:0],
                            (pwa_pkg::SUM_W - pwa_pkg::TS_W)'(0)};
        div_req.divisor  = per_eff;
        div_req.steps    = pwa_pkg::STEP_W'(pwa_pkg::TS_W);
      end
      S_START_EVERY: begin
        div_req.start    = 1'b1;
        div_req.dividend = {dist_q, (pwa_pkg::SUM_W - pwa_pkg::DIST_W)'(0)};
        div_req.divisor  = pwa_pkg::DIST_W'(every_eff);
        div_req.steps    = pwa_pkg::STEP_W'(pwa_pkg::DIST_W);
      end
      S_START_AVG: begin
        div_req.start    = 1'b1;
        div_req.dividend = sum_abs;
        div_req.divisor  = pwa_pkg::DIST_W'(rep_eff);
        div_req.steps    = pwa_pkg::STEP_W'(pwa_pkg::SUM_W);
      end
      default: ;
    endcase
  end

  pwa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    base    = first_q ? '0 : ram_rdata;
    acc_sum = {base[pwa_pkg::SUM_W-1], base}
            + (pwa_pkg::SUM_W + 1)'(sample_q);
    if (acc_sum[pwa_pkg::SUM_W] != acc_sum[pwa_pkg::SUM_W-1]) begin
      acc_sat = acc_sum[pwa_pkg::SUM_W] ? pwa_pkg::SUM_MIN : pwa_pkg::SUM_MAX;
    end else begin
      acc_sat = acc_sum[pwa_pkg::SUM_W-1:0];
    end
    sum_abs = sum_q[pwa_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
    if (&sum_q[pwa_pkg::SUM_W-1:pwa_pkg::VAL_W-1] ||
        ~|sum_q[pwa_pkg::SUM_W-1:pwa_pkg::VAL_W-1]) begin
      avg_sat = sum_q[pwa_pkg::VAL_W-1:0];
    end else begin
      avg_sat = sum_q[pwa_pkg::SUM_W-1] ? pwa_pkg::AVG_MIN : pwa_pkg::AVG_MAX;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    dist_d  = dist_q;
    take_d  = take_q;
    first_d = first_q;
    end_d   = end_q;
    sum_d   = sum_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_WAIT_PER;
        end
      end
      S_WAIT_PER: begin
        if (div_rsp.done) begin
          dist_d  = (div_rsp.rem == '0) ? '0 : per_eff - div_rsp.rem;
          state_d = S_START_EVERY;
        end
      end
      S_START_EVERY: begin
        state_d = S_WAIT_EVERY;
      end
      S_WAIT_EVERY: begin
        if (div_rsp.done) begin
          take_d  = slot_ok && (div_rsp.rem == '0)
                 && (pwa_pkg::SPAN_W'(dist_q) <= span_q)
                 && (ts_q >= start_q);
          first_d = pwa_pkg::SPAN_W'(dist_q) == span_q;
          end_d   = dist_q == '0;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        sum_d   = acc_sat;
        state_d = (take_q && end_q) ? S_START_AVG : S_OUT;
      end
      S_START_AVG: begin
        state_d = S_WAIT_AVG;
      end
      S_WAIT_AVG: begin
        if (div_rsp.done) begin
          sum_d   = sum_q[pwa_pkg::SUM_W-1] ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ts_q     <= s_axis_tdata_i[pwa_pkg::TS_W-1:0];
      slot_q   <= s_axis_tdata_i[pwa_pkg::TS_W +: pwa_pkg::SLOT_W];
      sample_q <= s_axis_tdata_i[pwa_pkg::TS_W + pwa_pkg::SLOT_W +: pwa_pkg::VAL_W];
      last_q   <= s_axis_tlast_i;
      span_q   <= pwa_pkg::SPAN_W'((pwa_pkg::SPAN_W'(rep_eff) - 1'b1)
                                   * pwa_pkg::SPAN_W'(every_eff));
    end
    dist_q  <= dist_d;
    take_q  <= take_d;
    first_q <= first_d;
    end_q   <= end_d;
    sum_q   <= sum_d;
    if (out_load) begin
      out_slot_q    <= slot_q;
      out_sampled_q <= take_q;
      out_done_q    <= take_q && end_q;
      out_avg_q     <= (take_q && end_q) ? avg_sat : '0;
      out_last_q    <= last_q;
    end
  end

  assign ram_we    = (state_q == S_CLEAR) || (out_load && take_q);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : slot_addr;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : sum_q;

  pwa_ram #(
    .Width (pwa_pkg::SUM_W),
    .Depth (SLOTS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_addr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(pwa_pkg::OUT_DATA_W - pwa_pkg::SLOT_W - pwa_pkg::VAL_W)'(0),
                            out_avg_q, out_slot_q};
  assign m_axis_tuser_o  = {out_done_q, out_sampled_q};
  assign m_axis_tlast_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> !s_axis_tready_o)
    else $error("second item accepted while one is in progress");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (ram_we && state_q != S_CLEAR) |-> (take_q && slot_ok))
    else $error("sum memory written for an item that was not sampled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      div_rsp.done |-> (state_q == S_WAIT_PER || state_q == S_WAIT_EVERY
                        || state_q == S_WAIT_AVG))
    else $error("divider result arrived outside a wait state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o |-> (!m_axis_tuser_o[1] || m_axis_tuser_o[0]))
    else $error("window end reported without a sample");

endmodule
`default_nettype wire

// ===== rtl/pwa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwa_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/pwa_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwa_div
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
// ----------------------------------------------------------------------------
module pwa_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pwa_pkg::div_req_t req_i,
  output pwa_pkg::div_rsp_t      rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [pwa_pkg::STEP_W-1:0]        cnt_q, cnt_d;
  logic [pwa_pkg::SUM_W-1:0]         quo_q, quo_d;
  logic [pwa_pkg::DIST_W-1:0]        rem_q, rem_d;
  logic [pwa_pkg::DIST_W-1:0]        dvs_q, dvs_d;
  logic [pwa_pkg::DIST_W:0]          part;
  logic [pwa_pkg::DIST_W:0]          diff;
  logic                              ge;

  always_comb begin
    part = {rem_q, quo_q[pwa_pkg::SUM_W-1]};
    ge   = part >= {1'b0, dvs_q};
    diff = part - {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[pwa_pkg::SUM_W-2:0], ge};
      rem_d = ge ? diff[pwa_pkg::DIST_W-1:0] : part[pwa_pkg::DIST_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == pwa_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (busy_q && !req_i.start && cnt_q == pwa_pkg::STEP_W'(1)) |=> done_q)
    else $error("divider missed its done pulse");

endmodule
`default_nettype wire

// ===== tb/sv/periodic_window_averager_test.sv =====
// ----------------------------------------------------------------------------
// periodic_window_averager_test
// Self-checking bench for the periodic window averager. Drives timestep items
// through the input stream, predicts each result from a local model of the
// per-slot window sums, and compares every output transaction field by field.
// Covers field extremes, zero registers, average saturation, back-pressure and
// randomized window sequences over several register settings.
// ----------------------------------------------------------------------------
module periodic_window_averager_test;

  localparam int unsigned NUM_SLOTS = 64;
  localparam int unsigned LONG_HOLD = 400;
  localparam longint unsigned TS_MAX = 64'h7fff_ffff;
  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint AVG_HI = 64'sd2147483647;
  localparam longint AVG_LO = -AVG_HI - 1;

  typedef struct packed {
    logic [pwa_pkg::TS_W-1:0]   ts;
    logic [pwa_pkg::SLOT_W-1:0] slot;
    logic [pwa_pkg::VAL_W-1:0]  sample;
    logic                       last_slot;
  } pwa_item_t;

  typedef struct packed {
    logic                       sampled;
    logic                       window_done;
    logic [pwa_pkg::SLOT_W-1:0] slot;
    logic [pwa_pkg::VAL_W-1:0]  average;
    logic                       last_slot;
  } pwa_result_t;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [pwa_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [pwa_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  // [30:0] timestep, [36:31] slot, [68:37] sample_value, [71:69] zero
  logic [pwa_pkg::IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  // last_slot
  logic                           s_axis_tlast_i = 1'b0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  // [5:0] slot_out, [37:6] average, [39:38] zero
  logic [pwa_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  // [0] sampled, [1] window_done
  logic [pwa_pkg::OUT_USER_W-1:0] m_axis_tuser_o;
  // last_out
  logic                           m_axis_tlast_o;

  logic [pwa_pkg::EVERY_W-1:0] every_reg;
  logic [pwa_pkg::REP_W-1:0]   repeat_reg;
  logic [pwa_pkg::DIST_W-1:0]  period_reg;
  logic [pwa_pkg::START_W-1:0] start_reg;
  longint             slot_sums [NUM_SLOTS];
  pwa_result_t        expected_results [$];
  int                 error_count = 0;
  int                 burst_left = 0;
  bit                 steady_sender = 1'b0;
  int                 hold_serial = 0;

  always #5 clk_i = ~clk_i;

  periodic_window_averager #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic pwa_result_t predict_average(pwa_item_t item);
    longint unsigned every;
    longint unsigned rep;
    longint unsigned per;
    longint unsigned win_end;
    longint unsigned win_dist;
    longint          win_start;
    longint          sum;
    pwa_result_t     res;
    every = (every_reg == 0) ? 64'd1 : 64'(every_reg);
    rep = (repeat_reg == 0) ? 64'd1 : 64'(repeat_reg);
    per = (period_reg == 0) ? 64'd1 : 64'(period_reg);
    win_end = ((64'(item.ts) + per - 1) / per) * per;
    win_start = longint'(win_end) - longint'((rep - 1) * every);
    win_dist = win_end - 64'(item.ts);
    res = '0;
    res.slot = item.slot;
    res.last_slot = item.last_slot;
    if (win_dist % every == 0 && longint'(64'(item.ts)) >= win_start &&
        item.ts >= start_reg) begin
      res.sampled = 1'b1;
      sum = slot_sums[item.slot];
      if (longint'(64'(item.ts)) == win_start) sum = 0;
      sum = clamp(sum + longint'($signed(item.sample)), SUM_LO, SUM_HI);
      if (64'(item.ts) == win_end) begin
        res.window_done = 1'b1;
        sum = sum / longint'(rep);
        res.average = pwa_pkg::VAL_W'(clamp(sum, AVG_LO, AVG_HI));
      end
      slot_sums[item.slot] = sum;
    end
    return res;
  endfunction

  function automatic pwa_item_t make_item(longint unsigned ts, int unsigned slot,
                                          logic [pwa_pkg::VAL_W-1:0] sample,
                                          bit last_slot);
    pwa_item_t item;
    item.ts = ts[pwa_pkg::TS_W-1:0];
    item.slot = slot[pwa_pkg::SLOT_W-1:0];
    item.sample = sample;
    item.last_slot = last_slot;
    return item;
  endfunction

  function automatic logic [pwa_pkg::VAL_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return pwa_pkg::AVG_MAX;
      1: return pwa_pkg::AVG_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pwa_pkg::CFG_IDX_W-1:0] index,
                           input logic [pwa_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      pwa_pkg::CFG_SAMPLE_EVERY:  every_reg = data[pwa_pkg::EVERY_W-1:0];
      pwa_pkg::CFG_REPEAT_COUNT:  repeat_reg = data[pwa_pkg::REP_W-1:0];
      pwa_pkg::CFG_WINDOW_PERIOD: period_reg = data[pwa_pkg::DIST_W-1:0];
      pwa_pkg::CFG_START_STEP:    start_reg = data[pwa_pkg::START_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int unsigned every, input int unsigned rep,
                              input int unsigned per, input int unsigned start);
    wait_drain();
    write_reg(pwa_pkg::CFG_SAMPLE_EVERY, every);
    write_reg(pwa_pkg::CFG_REPEAT_COUNT, rep);
    write_reg(pwa_pkg::CFG_WINDOW_PERIOD, per);
    write_reg(pwa_pkg::CFG_START_STEP, start);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(input pwa_item_t item);
    int gap;
    if (burst_left == 0 && !steady_sender) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= pwa_pkg::IN_DATA_W'({item.sample, item.slot, item.ts});
    s_axis_tlast_i <= item.last_slot;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_results.push_back(predict_average(item));
  endtask

  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    int         hold_left;
    int         hold_seen;
    logic [7:0] pattern;
    mode = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    pattern = 8'hff;
    forever begin
      @(posedge clk_i);
      if (hold_serial != hold_seen) begin
        hold_seen = hold_serial;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 80);
          pattern = 8'($urandom);
        end
        mode_left--;
        pattern = {pattern[6:0], pattern[7]};
        case (mode)
          SINK_OPEN:   m_axis_tready_i <= 1'b1;
          SINK_RANDOM: m_axis_tready_i <= 1'($urandom_range(0, 1));
          default:     m_axis_tready_i <= pattern[0];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    pwa_result_t got;
    pwa_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.sampled = m_axis_tuser_o[0];
      got.window_done = m_axis_tuser_o[1];
      got.slot = m_axis_tdata_o[5:0];
      got.average = m_axis_tdata_o[37:6];
      got.last_slot = m_axis_tlast_o;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result expected none got %0h", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("sampled", want.sampled, got.sampled);
        compare_field("window_done", want.window_done, got.window_done);
        compare_field("slot_out", want.slot, got.slot);
        compare_field("average", want.average, got.average);
        compare_field("last_out", want.last_slot, got.last_slot);
      end
    end
  end

  task automatic test_field_extremes();
    send_item(make_item(0, 0, pwa_pkg::AVG_MAX, 1'b0));
    send_item(make_item(TS_MAX, 63, pwa_pkg::AVG_MIN, 1'b1));
    send_item(make_item(1, 1, '0, 1'b0));
    send_item(make_item(2, 63, '1, 1'b1));
    send_item(make_item(64'h5555_5555, 42, 32'haaaa_aaaa, 1'b1));
    send_item(make_item(64'h2aaa_aaaa, 21, 32'h5555_5555, 1'b0));
  endtask

  task automatic test_zero_registers();
    apply_config(0, 0, 0, 0);
    send_item(make_item(7, 3, pick_sample(), 1'b1));
    send_item(make_item(TS_MAX, 10, pwa_pkg::AVG_MIN, 1'b0));
    send_item(make_item(12345, 63, pwa_pkg::AVG_MAX, 1'b1));
  endtask

  task automatic test_average_saturation();
    // accumulate without reaching the window end, then close with a small divisor
    apply_config(1, 1024, 1024, 0);
    for (int t = 1020; t < 1024; t++) begin
      send_item(make_item(t, 5, pwa_pkg::AVG_MAX, 1'b0));
      send_item(make_item(t, 6, pwa_pkg::AVG_MIN, 1'b1));
    end
    apply_config(1, 2, 1, 0);
    send_item(make_item(5000, 5, pwa_pkg::AVG_MAX, 1'b0));
    send_item(make_item(5000, 6, pwa_pkg::AVG_MIN, 1'b1));
  endtask

  task automatic test_backpressure();
    apply_config(2, 3, 6, 0);
    hold_serial <= hold_serial + 1;
    steady_sender = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_item(make_item(i + 1, i % 4, pick_sample(), (i % 4) == 3));
    end
    steady_sender = 1'b0;
    wait_drain();
  endtask

  task automatic run_window_phase(input int unsigned every, input int unsigned rep,
                                  input int unsigned per, input int unsigned start,
                                  input int n_items);
    int                         sent;
    longint unsigned            kmax;
    longint unsigned            k;
    longint unsigned            win_end;
    longint                     span;
    longint                     ts;
    int unsigned                j;
    int unsigned                jump;
    int unsigned                n_slots;
    logic [pwa_pkg::SLOT_W-1:0] slots [3];
    apply_config(every, rep, per, start);
    sent = 0;
    kmax = TS_MAX / per;
    span = longint'((rep - 1) * every);
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        ts = ($urandom_range(0, 7) == 0) ? TS_MAX : $urandom;
        send_item(make_item(ts, $urandom, pick_sample(), 1'($urandom)));
        sent++;
      end else begin
        case ($urandom_range(0, 2))
          0: k = $urandom_range(1, 3);
          1: k = start_reg / per + $urandom_range(0, 2);
          default: k = $urandom_range(1, 32'(kmax));
        endcase
        if (k > kmax) k = kmax;
        win_end = k * per;
        n_slots = $urandom_range(1, 3);
        foreach (slots[s]) slots[s] = pwa_pkg::SLOT_W'($urandom);
        // drop the window start now and then so the sum carries over
        j = (rep > 1 && $urandom_range(0, 4) == 0) ? 1 : 0;
        forever begin
          ts = longint'(win_end) - span + longint'(j) * longint'(every);
          if (ts >= 0) begin
            for (int s = 0; s < n_slots; s++) begin
              send_item(make_item(ts, slots[s], pick_sample(), s == n_slots - 1));
              sent++;
            end
          end
          if (j == rep - 1) break;
          jump = (rep > 6) ? $urandom_range(1, rep / 3) : 1;
          j = (j + jump > rep - 1) ? rep - 1 : j + jump;
        end
      end
    end
  endtask

  task automatic test_windows();
    int unsigned every;
    int unsigned rep;
    int unsigned per;
    int unsigned start;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin every = 1; rep = 4; per = 4; start = 0; end
        1: begin every = 3; rep = 5; per = 15; start = $urandom_range(0, 200); end
        2: begin every = 65535; rep = 3; per = 1048560; start = 0; end
        3: begin every = 7; rep = 1024; per = 1048575; start = 0; end
        4: begin every = 3; rep = 3; per = 4; start = $urandom_range(0, 40); end
        5: begin every = 5; rep = 2; per = 1048575; start = $urandom; end
        6: begin every = 2; rep = 6; per = 12; start = 32'(TS_MAX); end
        default: begin
          every = $urandom_range(1, 40);
          rep = $urandom_range(1, 12);
          per = ($urandom_range(0, 1) == 0) ? every * $urandom_range(1, 8)
                                            : $urandom_range(1, 300);
          start = $urandom_range(0, 1000);
        end
      endcase
      run_window_phase(every, rep, per, start, 48);
    end
  endtask

  initial begin : test_sequence
    every_reg = 1;
    repeat_reg = 1;
    period_reg = 1;
    start_reg = 0;
    foreach (slot_sums[i]) slot_sums[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_zero_registers();
    test_average_saturation();
    test_backpressure();
    test_windows();
    wait_drain();
    repeat (150) @(posedge clk_i);
    if (error_count == 0) begin
      $display("periodic_window_averager_test: done, clean");
    end else begin
      $display("periodic_window_averager_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("periodic_window_averager_test: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pwa_pkg.sv
rtl/pwa_ram.sv
rtl/pwa_div.sv
rtl/periodic_window_averager.sv
tb/sv/periodic_window_averager_test.sv
